// ----- sv/bfca_pkg.sv -----
// Shared constants, codes and types of the best-fit coalescing allocator.
package bfca_pkg;

  localparam int HEADER_BYTES_DEF = 24;
  localparam int MAX_BLOCKS_DEF = 256;
  localparam int SPLIT_SLACK = 4;
  localparam logic [16:0] POOL_MAX = 17'd65536;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE = 1'b1;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_BAD_FREE = 2'd2;

  // What the cell row looks for.
  localparam logic SRCH_MATCH = 1'b0;
  localparam logic SRCH_FREE_SLOT = 1'b1;

  typedef struct packed {
    logic        init;
    logic        we_live;
    logic        we_alloc;
    logic        we_off;
    logic        live;
    logic        alloc;
    logic [15:0] off;
  } cell_wr_t;

endpackage

// ----- sv/best_fit_coalescing_allocator.sv -----
// Top level of the best-fit coalescing allocator: sequencer, slot tables and cell row.
// An allocate word walks the recycled list from both ends, two entries per read and evaluate
// step; a split then adds a free-slot search through the cell row and table updates. A free
// word always runs one search through the cell row to find the block, then merging and list
// updates. One word is worked on at a time; a finished result waits in the output register
// while the next word is taken. After reset and after each pool_bytes write the pool is
// rebuilt in the S_INIT state.
module best_fit_coalescing_allocator import bfca_pkg::*; #(
  parameter int HEADER_BYTES = HEADER_BYTES_DEF,
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // request_bytes [15:0], free_offset [31:16]
  input  logic [0:0]  in_tuser,   // kind [0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // payload_offset [15:0], block_bytes [31:16]
  output logic [1:0]  out_tuser,  // status [1:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [16:0] cfg_data
);

  localparam int AW = $clog2(MAX_BLOCKS);
  localparam int IW = $clog2(MAX_BLOCKS + 1);
  localparam int GW = $clog2(MAX_BLOCKS + 2);
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam logic [IW-1:0] NIL = IW'(MAX_BLOCKS);
  localparam logic [15:0] HDR = 16'(HEADER_BYTES);
  localparam logic [16:0] POOL_MIN = 17'(HEADER_BYTES + 5);
  localparam logic [17:0] SPLIT_MIN = 18'(HEADER_BYTES + SPLIT_SLACK);

  localparam logic [4:0] S_INIT = 5'd0, S_IDLE = 5'd1, S_BF_RD = 5'd2, S_BF_EV = 5'd3,
    S_AL_PICK = 5'd4, S_AL_RD = 5'd5, S_AL_LAT = 5'd6, S_LR = 5'd7, S_AL_CHK = 5'd8,
    S_SRCH = 5'd9, S_AL_SLOT = 5'd10, S_SP1 = 5'd11, S_SP2 = 5'd12, S_AP1 = 5'd13,
    S_AP2 = 5'd14, S_GRANT = 5'd15, S_DONE = 5'd16, S_F_FOUND = 5'd17, S_F_RD = 5'd18,
    S_F_LAT = 5'd19, S_F_RDP = 5'd20, S_F_LATP = 5'd21, S_F_MRGP = 5'd22, S_F_NX = 5'd23,
    S_F_RDN = 5'd24, S_F_LATN = 5'd25, S_F_MRGN = 5'd26;

  logic [4:0]    state_r, ret_r;
  logic [16:0]   pool_r;
  logic [IW-1:0] head_r, tail_r, main_r;
  logic          mode_r, fromlist_r;
  logic [15:0]   req_r, foff_r;
  logic [IW-1:0] f_r, b_r, best_r, blk_r, ns_r, p_r, nx_r, bpn_r, npn_r, srch_r;
  logic [IW-1:0] lr_prev_r, lr_next_r, ap_r;
  logic [15:0]   best_size_r, bsize_r, boff_r, psize_r, nsize_r;
  logic [GW-1:0] guard_r;
  logic [CW-1:0] cnt_r;
  logic [1:0]    res_status_r;
  logic [15:0]   res_off_r, res_bytes_r;
  logic          out_valid_r;
  logic [1:0]    out_status_r;
  logic [15:0]   out_off_r, out_bytes_r;

  // Slot tables.
  logic [15:0]   m_size [MAX_BLOCKS];
  logic [15:0]   m_off  [MAX_BLOCKS];
  logic          m_alloc[MAX_BLOCKS];
  logic [IW-1:0] m_pn   [MAX_BLOCKS];
  logic [IW-1:0] m_pp   [MAX_BLOCKS];
  logic [IW-1:0] m_ln   [MAX_BLOCKS];
  logic [IW-1:0] m_lp   [MAX_BLOCKS];

  logic [15:0]   size_a, size_b, off_a;
  logic          alloc_a;
  logic [IW-1:0] pn_a, pp_a, ln_a, lp_a, lp_b;
  logic [IW-1:0] ra, rb;

  logic          sz_we, of_we, al_we, pn_we, pp_we, ln_we, lp_we;
  logic [IW-1:0] sz_wa, of_wa, al_wa, pn_wa, pp_wa, ln_wa, lp_wa;
  logic [15:0]   sz_wd, of_wd;
  logic          al_wd;
  logic [IW-1:0] pn_wd, pp_wd, ln_wd, lp_wd;

  cell_wr_t      cw;
  logic [IW-1:0] cw_idx;
  logic          ch_found;
  logic [IW-1:0] ch_idx;

  logic [16:0]   pool_sat;
  logic          f_fit, b_fit, cand_ok, can_split;
  logic [IW-1:0] cand;
  logic [15:0]   cand_size;

  assign pool_sat = (cfg_data < POOL_MIN) ? POOL_MIN :
                    ((cfg_data > POOL_MAX) ? POOL_MAX : cfg_data);
  assign can_split = ({2'b0, bsize_r} >= ({2'b0, req_r} + SPLIT_MIN));

  // Candidate of one scan step: the smaller fitting of the two, front on a tie.
  always_comb begin
    f_fit = (size_a >= req_r);
    b_fit = (size_b >= req_r);
    cand_ok = f_fit | b_fit;
    if (f_fit && b_fit) begin
      cand = (size_a > size_b) ? b_r : f_r;
      cand_size = (size_a > size_b) ? size_b : size_a;
    end else if (f_fit) begin
      cand = f_r;
      cand_size = size_a;
    end else begin
      cand = b_r;
      cand_size = size_b;
    end
  end

  always_comb begin
    ra = blk_r;
    rb = b_r;
    sz_we = 1'b0; sz_wa = blk_r; sz_wd = bsize_r;
    of_we = 1'b0; of_wa = ns_r;  of_wd = 16'(boff_r + HDR + req_r);
    al_we = 1'b0; al_wa = blk_r; al_wd = 1'b0;
    pn_we = 1'b0; pn_wa = blk_r; pn_wd = NIL;
    pp_we = 1'b0; pp_wa = ns_r;  pp_wd = blk_r;
    ln_we = 1'b0; ln_wa = ap_r;  ln_wd = NIL;
    lp_we = 1'b0; lp_wa = ap_r;  lp_wd = tail_r;
    cw = '0;
    cw_idx = blk_r;
    case (state_r)
      S_INIT: begin
        sz_we = 1'b1; sz_wa = '0; sz_wd = 16'(pool_r - 17'(HEADER_BYTES));
        of_we = 1'b1; of_wa = '0; of_wd = '0;
        al_we = 1'b1; al_wa = '0;
        pn_we = 1'b1; pn_wa = '0;
        pp_we = 1'b1; pp_wa = '0; pp_wd = NIL;
        cw.init = 1'b1; cw.we_off = 1'b1; cw_idx = '0;
      end
      S_BF_RD: begin
        ra = f_r;
        rb = b_r;
      end
      S_AL_RD, S_F_RD: ra = blk_r;
      S_F_RDP: ra = p_r;
      S_F_RDN: ra = nx_r;
      S_LR: begin
        ln_we = (lr_prev_r != NIL); ln_wa = lr_prev_r; ln_wd = lr_next_r;
        lp_we = (lr_next_r != NIL); lp_wa = lr_next_r; lp_wd = lr_prev_r;
      end
      S_SP1: begin
        sz_we = 1'b1; sz_wa = ns_r; sz_wd = 16'(bsize_r - HDR - req_r);
        of_we = 1'b1;
        al_we = 1'b1; al_wa = ns_r;
        pp_we = 1'b1;
        pn_we = 1'b1; pn_wa = ns_r; pn_wd = bpn_r;
        cw.we_live = 1'b1; cw.live = 1'b1; cw.we_alloc = 1'b1;
        cw.we_off = 1'b1; cw.off = of_wd; cw_idx = ns_r;
      end
      S_SP2: begin
        sz_we = 1'b1; sz_wd = req_r;
        pn_we = 1'b1; pn_wd = ns_r;
        pp_we = (bpn_r != NIL); pp_wa = bpn_r; pp_wd = ns_r;
      end
      S_AP1: begin
        ln_we = 1'b1;
        lp_we = 1'b1;
      end
      S_AP2: begin
        ln_we = (tail_r != NIL); ln_wa = tail_r; ln_wd = ap_r;
      end
      S_GRANT: begin
        al_we = 1'b1; al_wd = 1'b1;
        cw.we_alloc = 1'b1; cw.alloc = 1'b1;
      end
      S_F_LAT: begin
        al_we = 1'b1;
        cw.we_alloc = 1'b1;
      end
      S_F_MRGP: begin
        sz_we = 1'b1; sz_wa = p_r; sz_wd = 16'(psize_r + bsize_r + HDR);
        pn_we = 1'b1; pn_wa = p_r; pn_wd = bpn_r;
        pp_we = (bpn_r != NIL); pp_wa = bpn_r; pp_wd = p_r;
        cw.we_live = 1'b1;
      end
      S_F_LATN: begin
        if (nx_r == main_r) begin
          sz_we = 1'b1; sz_wd = 16'(bsize_r + size_a + HDR);
          pn_we = 1'b1;
          cw.we_live = 1'b1; cw_idx = nx_r;
        end
      end
      S_F_MRGN: begin
        sz_we = 1'b1; sz_wd = 16'(bsize_r + nsize_r + HDR);
        pn_we = 1'b1; pn_wd = npn_r;
        pp_we = (npn_r != NIL); pp_wa = npn_r; pp_wd = blk_r;
        cw.we_live = 1'b1; cw_idx = nx_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (sz_we) m_size[sz_wa[AW-1:0]] <= sz_wd;
    if (of_we) m_off[of_wa[AW-1:0]] <= of_wd;
    if (al_we) m_alloc[al_wa[AW-1:0]] <= al_wd;
    if (pn_we) m_pn[pn_wa[AW-1:0]] <= pn_wd;
    if (pp_we) m_pp[pp_wa[AW-1:0]] <= pp_wd;
    if (ln_we) m_ln[ln_wa[AW-1:0]] <= ln_wd;
    if (lp_we) m_lp[lp_wa[AW-1:0]] <= lp_wd;
    size_a  <= m_size[ra[AW-1:0]];
    off_a   <= m_off[ra[AW-1:0]];
    alloc_a <= m_alloc[ra[AW-1:0]];
    pn_a    <= m_pn[ra[AW-1:0]];
    pp_a    <= m_pp[ra[AW-1:0]];
    ln_a    <= m_ln[ra[AW-1:0]];
    lp_a    <= m_lp[ra[AW-1:0]];
    size_b  <= m_size[rb[AW-1:0]];
    lp_b    <= m_lp[rb[AW-1:0]];
  end

  bfca_chain #(.MAX_BLOCKS(MAX_BLOCKS), .HEADER_BYTES(HEADER_BYTES)) u_chain (
    .clk(clk), .rst_n(rst_n), .wr(cw), .wr_idx(cw_idx[AW-1:0]), .mode(mode_r),
    .key(foff_r), .found(ch_found), .idx(ch_idx)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      pool_r      <= POOL_MAX;
      head_r      <= NIL;
      tail_r      <= NIL;
      main_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // A result handed over in this cycle is replaced in S_DONE instead of cleared.
      if (out_valid_r && out_tready && state_r != S_DONE) out_valid_r <= 1'b0;
      case (state_r)
        S_INIT: begin
          head_r <= NIL;
          tail_r <= NIL;
          main_r <= '0;
          state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (cfg_valid) begin
            pool_r <= pool_sat;
            state_r <= S_INIT;
          end else if (in_tvalid) begin
            req_r <= in_tdata[15:0];
            foff_r <= in_tdata[31:16];
            f_r <= head_r;
            b_r <= tail_r;
            best_r <= NIL;
            guard_r <= '0;
            mode_r <= SRCH_MATCH;
            cnt_r <= '0;
            ret_r <= S_F_FOUND;
            state_r <= (in_tuser[0] == KIND_ALLOC) ? S_BF_RD : S_SRCH;
          end
        end
        S_BF_RD: begin
          if (f_r != NIL && b_r != NIL && guard_r <= GW'(MAX_BLOCKS)) state_r <= S_BF_EV;
          else state_r <= S_AL_PICK;
        end
        S_BF_EV: begin
          if (size_a == req_r) begin
            best_r <= f_r;
            state_r <= S_AL_PICK;
          end else if (size_b == req_r) begin
            best_r <= b_r;
            state_r <= S_AL_PICK;
          end else if (f_r == b_r) begin
            if (f_fit && (best_r == NIL || best_size_r > size_a)) best_r <= f_r;
            state_r <= S_AL_PICK;
          end else begin
            if (cand_ok && (best_r == NIL || best_size_r > cand_size)) begin
              best_r <= cand;
              best_size_r <= cand_size;
            end
            f_r <= ln_a;
            b_r <= lp_b;
            guard_r <= guard_r + 1'b1;
            state_r <= S_BF_RD;
          end
        end
        S_AL_PICK: begin
          if (best_r != NIL) begin
            blk_r <= best_r;
            fromlist_r <= 1'b1;
            state_r <= S_AL_RD;
          end else if (main_r != NIL) begin
            blk_r <= main_r;
            fromlist_r <= 1'b0;
            state_r <= S_AL_RD;
          end else begin
            res_status_r <= ST_NO_SPACE;
            res_off_r <= '0;
            res_bytes_r <= '0;
            state_r <= S_DONE;
          end
        end
        S_AL_RD: state_r <= S_AL_LAT;
        S_AL_LAT: begin
          bsize_r <= size_a;
          boff_r <= off_a;
          bpn_r <= pn_a;
          lr_prev_r <= lp_a;
          lr_next_r <= ln_a;
          ret_r <= S_AL_CHK;
          state_r <= fromlist_r ? S_LR : S_AL_CHK;
        end
        S_LR: begin
          if (lr_prev_r == NIL) head_r <= lr_next_r;
          if (lr_next_r == NIL) tail_r <= lr_prev_r;
          state_r <= ret_r;
        end
        S_AL_CHK: begin
          if (can_split) begin
            mode_r <= SRCH_FREE_SLOT;
            cnt_r <= '0;
            ret_r <= S_AL_SLOT;
            state_r <= S_SRCH;
          end else if (fromlist_r) begin
            state_r <= S_GRANT;
          end else if (bsize_r >= req_r) begin
            main_r <= NIL;
            state_r <= S_GRANT;
          end else begin
            res_status_r <= ST_NO_SPACE;
            res_off_r <= '0;
            res_bytes_r <= '0;
            state_r <= S_DONE;
          end
        end
        S_SRCH: begin
          // The last cell holds the answer once the hit has rippled through every cell.
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CW'(MAX_BLOCKS)) begin
            srch_r <= ch_found ? ch_idx : NIL;
            state_r <= ret_r;
          end
        end
        S_AL_SLOT: begin
          ns_r <= srch_r;
          if (srch_r != NIL) begin
            state_r <= S_SP1;
          end else begin
            if (!fromlist_r) main_r <= NIL;
            state_r <= S_GRANT;
          end
        end
        S_SP1: state_r <= S_SP2;
        S_SP2: begin
          bsize_r <= req_r;
          if (fromlist_r) begin
            ap_r <= ns_r;
            ret_r <= S_GRANT;
            state_r <= S_AP1;
          end else begin
            main_r <= ns_r;
            state_r <= S_GRANT;
          end
        end
        S_AP1: state_r <= S_AP2;
        S_AP2: begin
          if (tail_r == NIL) head_r <= ap_r;
          tail_r <= ap_r;
          state_r <= ret_r;
        end
        S_GRANT: begin
          res_status_r <= ST_OK;
          res_off_r <= 16'(boff_r + HDR);
          res_bytes_r <= bsize_r;
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_status_r <= res_status_r;
            out_off_r <= res_off_r;
            out_bytes_r <= res_bytes_r;
            state_r <= S_IDLE;
          end
        end
        S_F_FOUND: begin
          res_off_r <= foff_r;
          if (srch_r == NIL) begin
            res_status_r <= ST_BAD_FREE;
            res_bytes_r <= '0;
            state_r <= S_DONE;
          end else begin
            res_status_r <= ST_OK;
            blk_r <= srch_r;
            state_r <= S_F_RD;
          end
        end
        S_F_RD: state_r <= S_F_LAT;
        S_F_LAT: begin
          bsize_r <= size_a;
          bpn_r <= pn_a;
          p_r <= pp_a;
          res_bytes_r <= size_a;
          state_r <= (pp_a != NIL) ? S_F_RDP : S_F_NX;
        end
        S_F_RDP: state_r <= S_F_LATP;
        S_F_LATP: begin
          psize_r <= size_a;
          lr_prev_r <= lp_a;
          lr_next_r <= ln_a;
          ret_r <= S_F_MRGP;
          state_r <= alloc_a ? S_F_NX : S_LR;
        end
        S_F_MRGP: begin
          blk_r <= p_r;
          bsize_r <= 16'(psize_r + bsize_r + HDR);
          state_r <= S_F_NX;
        end
        S_F_NX: begin
          nx_r <= bpn_r;
          ap_r <= blk_r;
          ret_r <= S_DONE;
          if (bpn_r == NIL && main_r == NIL) begin
            main_r <= blk_r;
            state_r <= S_DONE;
          end else if (bpn_r != NIL) begin
            state_r <= S_F_RDN;
          end else begin
            state_r <= S_AP1;
          end
        end
        S_F_RDN: state_r <= S_F_LATN;
        S_F_LATN: begin
          nsize_r <= size_a;
          npn_r <= pn_a;
          lr_prev_r <= lp_a;
          lr_next_r <= ln_a;
          if (nx_r == main_r) begin
            main_r <= blk_r;
            state_r <= S_DONE;
          end else if (!alloc_a) begin
            ret_r <= S_F_MRGN;
            state_r <= S_LR;
          end else begin
            state_r <= S_AP1;
          end
        end
        S_F_MRGN: begin
          bsize_r <= 16'(bsize_r + nsize_r + HDR);
          ret_r <= S_DONE;
          state_r <= S_AP1;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready = (state_r == S_IDLE) && !cfg_valid;
  assign cfg_ready = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata = {out_bytes_r, out_off_r};
  assign out_tuser = out_status_r;

endmodule

// ----- sv/bfca_cell.sv -----
// One slot cell: holds the slot's live, allocated and offset state and passes the first hit on.
module bfca_cell import bfca_pkg::*; #(
  parameter int IDX = 0,
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF,
  localparam int AW = $clog2(MAX_BLOCKS),
  localparam int IW = $clog2(MAX_BLOCKS + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  cell_wr_t      wr,
  input  logic [AW-1:0] wr_idx,
  input  logic          mode,
  input  logic [15:0]   key,
  input  logic          found_in,
  input  logic [IW-1:0] idx_in,
  output logic          found_out,
  output logic [IW-1:0] idx_out
);

  logic        live_r;
  logic        alloc_r;
  logic [15:0] off_r;
  logic        found_r;
  logic [IW-1:0] idx_r;
  logic        hit;
  logic        sel;

  assign sel = (wr_idx == AW'(IDX));
  assign hit = (mode == SRCH_FREE_SLOT) ? ~live_r :
               (live_r & alloc_r &
                (({1'b0, off_r} + 17'(HEADER_BYTES)) == {1'b0, key}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r  <= (IDX == 0);
      alloc_r <= 1'b0;
      found_r <= 1'b0;
      idx_r   <= IW'(MAX_BLOCKS);
    end else begin
      if (wr.init) begin
        live_r  <= (IDX == 0);
        alloc_r <= 1'b0;
      end
      if (sel && wr.we_live) live_r <= wr.live;
      if (sel && wr.we_alloc) alloc_r <= wr.alloc;
      // The earliest hit upstream wins over this cell's own.
      found_r <= found_in | hit;
      idx_r   <= found_in ? idx_in : (hit ? IW'(IDX) : IW'(MAX_BLOCKS));
    end
  end

  always_ff @(posedge clk) begin
    if (sel && wr.we_off) off_r <= wr.off;
  end

  assign found_out = found_r;
  assign idx_out = idx_r;

endmodule

// ----- sv/bfca_chain.sv -----
// Row of slot cells that finds the lowest slot matching the current search.
module bfca_chain import bfca_pkg::*; #(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF,
  localparam int AW = $clog2(MAX_BLOCKS),
  localparam int IW = $clog2(MAX_BLOCKS + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  cell_wr_t      wr,
  input  logic [AW-1:0] wr_idx,
  input  logic          mode,
  input  logic [15:0]   key,
  output logic          found,
  output logic [IW-1:0] idx
);

  logic          fnd [MAX_BLOCKS+1];
  logic [IW-1:0] ix  [MAX_BLOCKS+1];

  assign fnd[0] = 1'b0;
  assign ix[0] = IW'(MAX_BLOCKS);

  for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
    bfca_cell #(
      .IDX(i), .MAX_BLOCKS(MAX_BLOCKS), .HEADER_BYTES(HEADER_BYTES)
    ) u_cell (
      .clk(clk), .rst_n(rst_n), .wr(wr), .wr_idx(wr_idx), .mode(mode), .key(key),
      .found_in(fnd[i]), .idx_in(ix[i]), .found_out(fnd[i+1]), .idx_out(ix[i+1])
    );
  end

  assign found = fnd[MAX_BLOCKS];
  assign idx = ix[MAX_BLOCKS];

endmodule
